@@ design/prld_pkg.sv @@
// Package for the PCX line decoder: widths, limits, register indexes,
// and the item type that goes from the front part to the back part.
// No dependencies.
`default_nettype none

package prld_pkg;

	localparam int MAX_LINE = 4096;
	localparam int MAX_ROWS = 4096;

	localparam int CFG_W   = 13;
	localparam int CNT_W   = 6;
	localparam int COORD_W = 12;
	localparam int PIX_W   = 8;

	localparam logic [PIX_W-1:0] RUN_MASK  = 8'hC0;
	localparam logic [PIX_W-1:0] COUNT_MASK = 8'h3F;

	localparam logic [CFG_W-1:0] MAX_LINE_C = CFG_W'(MAX_LINE);
	localparam logic [CFG_W-1:0] MAX_ROWS_C = CFG_W'(MAX_ROWS);

	localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = CFG_W'(320);
	localparam logic [CFG_W-1:0] RST_LINE_BYTES   = CFG_W'(320);
	localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = CFG_W'(200);

	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_LINE_BYTES   = 2'd1,
		REG_IMAGE_HEIGHT = 2'd2
	} prld_reg_t;

	// One decoded byte: a span of stored pixels on one row, or none.
	typedef struct packed {
		logic [COORD_W-1:0] start_col;
		logic [COORD_W-1:0] row;
		logic [PIX_W-1:0]   value;
		logic [CNT_W-1:0]   num_pix;
		logic               done;
	} prld_item_t;

endpackage

`default_nettype wire

@@ design/prld_front.sv @@
// Front part of the PCX line decoder: holds the configuration registers,
// classifies each byte and tracks line position and row. Uses prld_pkg.
`default_nettype none

module prld_front import prld_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [CFG_W-1:0]   cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [PIX_W-1:0]   code_byte,
	input  wire logic               frame_start,
	output logic                    push,
	output prld_item_t              push_item,
	input  wire logic               q_full
);

	logic [CFG_W-1:0] width_q, lbytes_q, height_q;
	logic             await_q;
	logic [CNT_W-1:0] pend_q;
	logic [CFG_W-1:0] pos_q, row_q;
	logic             fin_q;

	logic             aw, fin0, fin1, have, line_end;
	logic [CNT_W-1:0] pc, count;
	logic [CFG_W-1:0] pos, rw, lb, w, h, room, adv, wroom, nstore, newpos, row_inc;
	logic             aw_n, fin_n;
	logic [CNT_W-1:0] pc_n;
	logic [CFG_W-1:0] pos_n, row_n;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_IMAGE_WIDTH;
			lbytes_q <= RST_LINE_BYTES;
			height_q <= RST_IMAGE_HEIGHT;
		end else if (cfg_we) begin
			unique case (prld_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_LINE_BYTES:   lbytes_q <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		// frame start clears position before the byte is decoded
		aw   = frame_start ? 1'b0 : await_q;
		pc   = frame_start ? '0 : pend_q;
		pos  = frame_start ? '0 : pos_q;
		rw   = frame_start ? '0 : row_q;
		fin0 = frame_start ? 1'b0 : fin_q;

		lb = (lbytes_q > MAX_LINE_C) ? MAX_LINE_C : lbytes_q;
		w  = (width_q < lb) ? width_q : lb;
		h  = (height_q > MAX_ROWS_C) ? MAX_ROWS_C : height_q;

		fin1 = fin0 || (rw >= h);

		aw_n  = aw;
		pc_n  = pc;
		count = '0;
		have  = 1'b0;
		if (!fin1) begin
			if (aw) begin
				count = pc;
				have  = 1'b1;
				aw_n  = 1'b0;
				pc_n  = '0;
			end else if ((code_byte & RUN_MASK) == RUN_MASK) begin
				aw_n = 1'b1;
				pc_n = CNT_W'(code_byte & COUNT_MASK);
			end else begin
				count = CNT_W'(1);
				have  = 1'b1;
			end
		end

		room   = (pos < lb) ? (lb - pos) : '0;
		adv    = ({{(CFG_W-CNT_W){1'b0}}, count} < room) ?
			{{(CFG_W-CNT_W){1'b0}}, count} : room;
		wroom  = (pos < w) ? (w - pos) : '0;
		nstore = (adv < wroom) ? adv : wroom;
		newpos = pos + adv;
		row_inc = rw + CFG_W'(1);
		line_end = have && (newpos >= lb);

		pos_n = pos;
		row_n = rw;
		fin_n = fin1;
		if (have) begin
			pos_n = newpos;
			if (line_end) begin
				pos_n = '0;
				row_n = row_inc;
				if (row_inc >= h) fin_n = 1'b1;
			end
		end

		push_item.start_col = pos[COORD_W-1:0];
		push_item.row       = rw[COORD_W-1:0];
		push_item.value     = code_byte;
		push_item.num_pix   = have ? nstore[CNT_W-1:0] : '0;
		push_item.done      = fin_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			await_q <= 1'b0;
			pend_q  <= '0;
			pos_q   <= '0;
			row_q   <= '0;
			fin_q   <= 1'b0;
		end else if (push) begin
			await_q <= aw_n;
			pend_q  <= pc_n;
			pos_q   <= pos_n;
			row_q   <= row_n;
			fin_q   <= fin_n;
		end
	end

endmodule

`default_nettype wire

@@ design/prld_queue.sv @@
// Two-entry show-ahead queue between the front and back parts of the
// PCX line decoder. Uses prld_pkg for the item type.
`default_nettype none

module prld_queue import prld_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire prld_item_t push_item,
	output logic            full,
	input  wire logic       pop,
	output logic            head_valid,
	output prld_item_t      head_item
);

	prld_item_t mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ design/prld_back.sv @@
// Back part of the PCX line decoder: expands each queued item into its
// pixels, one per cycle unless out_ready stalls, into the output register. Uses prld_pkg.
`default_nettype none

module prld_back import prld_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               head_valid,
	input  wire prld_item_t         head_item,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    pixel_valid,
	output logic [PIX_W-1:0]        pixel_value,
	output logic [COORD_W-1:0]      column,
	output logic [COORD_W-1:0]      row,
	output logic                    last_of_item,
	output logic                    image_done
);

	logic [CNT_W-1:0] idx_q;
	logic             ovalid_q;
	logic             load, empty_span, last;

	always_comb begin
		load       = head_valid && (!ovalid_q || out_ready);
		empty_span = (head_item.num_pix == '0);
		last       = empty_span || (idx_q == head_item.num_pix - CNT_W'(1));
		pop        = load && last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (load) begin
				ovalid_q <= 1'b1;
				idx_q    <= last ? '0 : idx_q + CNT_W'(1);
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// payload: no reset needed
	always_ff @(posedge clk) begin
		if (load) begin
			pixel_valid  <= !empty_span;
			pixel_value  <= empty_span ? '0 : head_item.value;
			column       <= empty_span ? '0 :
				head_item.start_col + {{(COORD_W-CNT_W){1'b0}}, idx_q};
			row          <= empty_span ? '0 : head_item.row;
			last_of_item <= last;
			image_done   <= head_item.done;
		end
	end

	assign out_valid = ovalid_q;

endmodule

`default_nettype wire

@@ design/pcx_rle_line_decoder_top.sv @@
// Top level of the PCX 8-bit run-length line decoder.
// Instantiates prld_front, prld_queue and prld_back; uses prld_pkg.
//
//   channel | handshake                   | payload
//   --------+-----------------------------+---------------------------------------
//   in      | in_valid / in_ready         | code_byte, frame_start
//   out     | out_valid / out_ready       | pixel_valid, pixel_value, column, row,
//           |                             | last_of_item, image_done
//   cfg     | cfg_we (no wait)            | cfg_index, cfg_data
//
// The front takes one byte per cycle while the two-entry queue has room.
// The back sends one result per cycle while out_ready is high: one for
// each stored pixel of a byte (up to 63), or one for a byte with none.
// The back's expansion counter sets the sustained rate. Reset loads width
// 320, line bytes 320, height 200 and clears position; out_ready low holds
// the output register and fills the queue, after which in_ready drops.
`default_nettype none

module pcx_rle_line_decoder_top import prld_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [CFG_W-1:0]   cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [PIX_W-1:0]   code_byte,
	input  wire logic               frame_start,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    pixel_valid,
	output logic [PIX_W-1:0]        pixel_value,
	output logic [COORD_W-1:0]      column,
	output logic [COORD_W-1:0]      row,
	output logic                    last_of_item,
	output logic                    image_done
);

	logic       push, q_full, pop, head_valid;
	prld_item_t push_item, head_item;

	prld_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.code_byte  (code_byte),
		.frame_start(frame_start),
		.push       (push),
		.push_item  (push_item),
		.q_full     (q_full)
	);

	prld_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_item (head_item)
	);

	prld_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_item   (head_item),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_valid (pixel_valid),
		.pixel_value (pixel_value),
		.column      (column),
		.row         (row),
		.last_of_item(last_of_item),
		.image_done  (image_done)
	);

endmodule

`default_nettype wire
